// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent overlaps consequent
`define CHK_OVL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: lbl");

// consequent in the cycle after antecedent
`define CHK_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: lbl");

`endif

// ===== hw/rtl/dlf_pkg.sv =====
// shared types, constants and sigmoid tables of the dense layer unit
package dlf_pkg;

	localparam int MAX_INPUTS     = 1024;
	localparam int MAX_NEURONS    = 64;
	localparam int SIG_DEPTH      = 256;
	localparam int SIG_IDX_W      = $clog2(SIG_DEPTH);
	localparam int NEUR_W         = 6;
	localparam int ROW_W          = 10;
	localparam int CNT_W          = 11;
	localparam int OCNT_W         = 7;
	localparam int VAL_W          = 16;
	localparam int PROD_W         = 2 * VAL_W;
	localparam int ACC_W          = 40;
	localparam int SLOPE_W        = 13;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 11;
	localparam int OUT_DEPTH      = 4;
	localparam int OUT_PTR_W      = $clog2(OUT_DEPTH);
	localparam int CREDIT_W       = $clog2(OUT_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUTS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS = 2'd2;

	localparam logic [CNT_W-1:0]  INPUTS_RESET  = 11'd784;
	localparam logic [OCNT_W-1:0] OUTPUTS_RESET = 7'd64;

	typedef enum logic [1:0] {
		CMD_WEIGHT = 2'd0,
		CMD_BIAS   = 2'd1,
		CMD_ACT    = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic              mac_issue;
		logic              eval_issue;
		logic              last;
		logic              clear_acc;
		logic              sig_mode;
		logic [ROW_W-1:0]  row;
		logic [NEUR_W-1:0] neuron;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pop;
	} dp_status_t;

	typedef struct packed {
		logic [NEUR_W-1:0]  neuron;
		logic [VAL_W-1:0]   act;
		logic [SLOPE_W-1:0] slope;
		logic               last;
	} out_item_t;

	typedef logic [SLOPE_W-1:0] sig_rom_t [SIG_DEPTH];

	// long division for the table build
	function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [SLOPE_W-1:0] sig_entry(int i);
		longint          xq;
		longint unsigned t;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned den;
		longint unsigned p;
		xq = -32768 + (longint'(i) * 65536) / SIG_DEPTH;
		t = (xq < 0) ? longint'(-xq) : longint'(xq);
		term = 64'd1 << 24;
		sum = term;
		for (int n = 1; n <= 64; n++) begin
			if (term != 0) begin
				term = udiv(term * t, longint'(n) * 4096);
				sum = sum + term;
			end
		end
		den = (64'd1 << 24) + sum;
		p = udiv((64'd1 << 36) + (den >> 1), den);
		if (xq < 0)
			return SLOPE_W'(p);
		return SLOPE_W'(64'd4096 - p);
	endfunction

	function automatic sig_rom_t sig_act_rom();
		sig_rom_t r;
		for (int i = 0; i < SIG_DEPTH; i++)
			r[i] = sig_entry(i);
		return r;
	endfunction

	function automatic sig_rom_t sig_slope_rom();
		sig_rom_t        r;
		longint unsigned s;
		for (int i = 0; i < SIG_DEPTH; i++) begin
			s = longint'(sig_entry(i));
			r[i] = SLOPE_W'((s * (64'd4096 - s) + 64'd2048) >> 12);
		end
		return r;
	endfunction

	localparam sig_rom_t SIG_ACT_ROM   = sig_act_rom();
	localparam sig_rom_t SIG_SLOPE_ROM = sig_slope_rom();

endpackage

// ===== hw/rtl/dlf_ctrl.sv =====
// controller: configuration registers, run sequencing and output credits
module dlf_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dlf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dlf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	input  logic [1:0]                       command,
	output logic                             in_ready,
	input  dlf_pkg::dp_status_t              status,
	output dlf_pkg::ctrl_cmd_t               cmd
);

	dlf_pkg::state_t                  state_q, state_d;
	logic                             mode_q;
	logic [dlf_pkg::CNT_W-1:0]        in_cnt_q;
	logic [dlf_pkg::OCNT_W-1:0]       out_cnt_q;
	logic [dlf_pkg::CNT_W-1:0]        seen_q;
	logic [dlf_pkg::NEUR_W-1:0]       n_q;
	logic                             drain_q;
	logic [dlf_pkg::CREDIT_W-1:0]     credit_q;
	logic [dlf_pkg::CNT_W-1:0]        n_in;
	logic [dlf_pkg::NEUR_W-1:0]       n_last;
	logic                             run_done;
	logic                             act_accept;
	logic                             is_last;
	logic                             eval_go;

	always_comb begin
		if (in_cnt_q == '0)
			n_in = dlf_pkg::CNT_W'(1);
		else if (in_cnt_q > dlf_pkg::CNT_W'(dlf_pkg::MAX_INPUTS))
			n_in = dlf_pkg::CNT_W'(dlf_pkg::MAX_INPUTS);
		else
			n_in = in_cnt_q;
		if (out_cnt_q == '0)
			n_last = '0;
		else if (out_cnt_q > dlf_pkg::OCNT_W'(dlf_pkg::MAX_NEURONS))
			n_last = dlf_pkg::NEUR_W'(dlf_pkg::MAX_NEURONS - 1);
		else
			n_last = dlf_pkg::NEUR_W'(out_cnt_q - 1'b1);
	end

	assign run_done   = ({1'b0, seen_q} + 12'd1) >= {1'b0, n_in};
	assign act_accept = in_valid && in_ready && (command == dlf_pkg::CMD_ACT);
	assign is_last    = (n_q == n_last);
	assign eval_go    = (state_q == dlf_pkg::ST_EVAL) &&
		(credit_q < dlf_pkg::CREDIT_W'(dlf_pkg::OUT_DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dlf_pkg::ST_IDLE: begin
				if (act_accept)
					state_d = dlf_pkg::ST_MAC;
			end
			dlf_pkg::ST_MAC: begin
				if (is_last)
					state_d = dlf_pkg::ST_DRAIN;
			end
			dlf_pkg::ST_DRAIN: begin
				if (!drain_q)
					state_d = run_done ? dlf_pkg::ST_EVAL : dlf_pkg::ST_IDLE;
			end
			dlf_pkg::ST_EVAL: begin
				if (eval_go && is_last)
					state_d = dlf_pkg::ST_IDLE;
			end
			default: state_d = dlf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == dlf_pkg::ST_IDLE);
		cmd.mac_issue  = (state_q == dlf_pkg::ST_MAC);
		cmd.eval_issue = eval_go;
		cmd.last       = is_last;
		cmd.clear_acc  = eval_go && is_last;
		cmd.sig_mode   = mode_q;
		cmd.row        = seen_q[dlf_pkg::ROW_W-1:0];
		cmd.neuron     = n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dlf_pkg::ST_IDLE;
			mode_q    <= 1'b0;
			in_cnt_q  <= dlf_pkg::INPUTS_RESET;
			out_cnt_q <= dlf_pkg::OUTPUTS_RESET;
			seen_q    <= '0;
			n_q       <= '0;
			drain_q   <= 1'b0;
			credit_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					dlf_pkg::CFG_MODE:    mode_q    <= cfg_data[0];
					dlf_pkg::CFG_INPUTS:  in_cnt_q  <= cfg_data;
					dlf_pkg::CFG_OUTPUTS: out_cnt_q <= cfg_data[dlf_pkg::OCNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.mac_issue || eval_go)
				n_q <= is_last ? '0 : n_q + 1'b1;
			if (cmd.mac_issue && is_last)
				drain_q <= 1'b1;
			else
				drain_q <= 1'b0;
			if (state_q == dlf_pkg::ST_DRAIN && !drain_q)
				seen_q <= run_done ? '0 : seen_q + 1'b1;
			case ({eval_go, status.pop})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/dlf_datapath.sv =====
// datapath: weight, bias and accumulator stores, mac pipeline, activation and result queue
module dlf_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dlf_pkg::ctrl_cmd_t              cmd,
	input  logic                            in_accept,
	input  logic [1:0]                      command,
	input  logic [dlf_pkg::ROW_W-1:0]       source_index,
	input  logic [dlf_pkg::NEUR_W-1:0]      neuron_select,
	input  logic signed [dlf_pkg::VAL_W-1:0] operand_value,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [dlf_pkg::NEUR_W-1:0]      neuron_number,
	output logic signed [dlf_pkg::VAL_W-1:0] activation_out,
	output logic [dlf_pkg::SLOPE_W-1:0]     slope_out,
	output logic                            final_result,
	output dlf_pkg::dp_status_t             status
);

	localparam int WADDR_W = dlf_pkg::ROW_W + dlf_pkg::NEUR_W;
	localparam int Z_W     = dlf_pkg::ACC_W + 1;
	localparam int ZQ_W    = Z_W - 12;

	logic [dlf_pkg::VAL_W-1:0]   wmem_q [2**WADDR_W];
	logic [dlf_pkg::VAL_W-1:0]   bmem_q [dlf_pkg::MAX_NEURONS];
	logic [dlf_pkg::ACC_W-1:0]   amem_q [dlf_pkg::MAX_NEURONS];
	logic [dlf_pkg::MAX_NEURONS-1:0] acc_vld_q;
	logic signed [dlf_pkg::VAL_W-1:0] val_q;

	logic                        mac_s1, fin_s1, mac_s2, fin_s2;
	logic [dlf_pkg::NEUR_W-1:0]  n_s1, n_s2;
	logic                        last_s1, last_s2, mode_s1, mode_s2;
	logic                        vld_s1;
	logic signed [dlf_pkg::VAL_W-1:0] w_s1, b_s1;
	logic signed [dlf_pkg::ACC_W-1:0] acc_s1, acc_s2;
	logic signed [dlf_pkg::PROD_W-1:0] prod_s2;
	logic signed [dlf_pkg::VAL_W-1:0] zq_s2;
	logic                        pos_s2;

	logic signed [dlf_pkg::ACC_W-1:0] acc_eff;
	logic signed [Z_W-1:0]       z;
	logic signed [ZQ_W-1:0]      zfl;
	logic signed [dlf_pkg::VAL_W-1:0] zq;
	logic signed [Z_W-1:0]       sum;
	logic signed [dlf_pkg::ACC_W-1:0] sum_sat;
	logic [dlf_pkg::VAL_W-1:0]   zu;
	logic [dlf_pkg::SIG_IDX_W-1:0] sidx;
	dlf_pkg::out_item_t          item;

	dlf_pkg::out_item_t          fifo_q [dlf_pkg::OUT_DEPTH];
	logic [dlf_pkg::OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [dlf_pkg::CREDIT_W-1:0]  count_q;
	logic                        push, pop;

	// stores
	always_ff @(posedge clk) begin
		if (in_accept && command == dlf_pkg::CMD_WEIGHT)
			wmem_q[{source_index, neuron_select}] <= operand_value;
		w_s1 <= wmem_q[{cmd.row, cmd.neuron}];
	end

	always_ff @(posedge clk) begin
		if (in_accept && command == dlf_pkg::CMD_BIAS)
			bmem_q[neuron_select] <= operand_value;
		b_s1 <= bmem_q[cmd.neuron];
	end

	always_ff @(posedge clk) begin
		if (mac_s2)
			amem_q[n_s2] <= sum_sat;
		acc_s1 <= amem_q[cmd.neuron];
	end

	always_ff @(posedge clk) begin
		if (in_accept && command == dlf_pkg::CMD_ACT)
			val_q <= operand_value;
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1    <= 1'b0;
			fin_s1    <= 1'b0;
			mac_s2    <= 1'b0;
			fin_s2    <= 1'b0;
			acc_vld_q <= '0;
		end else begin
			mac_s1 <= cmd.mac_issue;
			fin_s1 <= cmd.eval_issue;
			mac_s2 <= mac_s1;
			fin_s2 <= fin_s1;
			if (cmd.clear_acc)
				acc_vld_q <= '0;
			else if (mac_s2)
				acc_vld_q[n_s2] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		n_s1    <= cmd.neuron;
		last_s1 <= cmd.last;
		mode_s1 <= cmd.sig_mode;
		vld_s1  <= acc_vld_q[cmd.neuron];
		n_s2    <= n_s1;
		last_s2 <= last_s1;
		mode_s2 <= mode_s1;
		prod_s2 <= val_q * w_s1;
		acc_s2  <= acc_eff;
		zq_s2   <= zq;
		pos_s2  <= (z > 0);
	end

	// accumulate with saturation
	always_comb begin
		acc_eff = vld_s1 ? acc_s1 : '0;
		sum = Z_W'(acc_s2) + Z_W'(prod_s2);
		if (sum[Z_W-1] != sum[Z_W-2])
			sum_sat = sum[Z_W-1] ? {1'b1, {(dlf_pkg::ACC_W-1){1'b0}}}
				: {1'b0, {(dlf_pkg::ACC_W-1){1'b1}}};
		else
			sum_sat = sum[dlf_pkg::ACC_W-1:0];
	end

	// preactivation, floor to q4.12 and saturate
	always_comb begin
		z = Z_W'(acc_eff) + (Z_W'(b_s1) <<< 12);
		zfl = z[Z_W-1:12];
		if (zfl > ZQ_W'(32767))
			zq = 16'sh7fff;
		else if (zfl < -ZQ_W'(32768))
			zq = 16'sh8000;
		else
			zq = zfl[dlf_pkg::VAL_W-1:0];
	end

	// activation
	always_comb begin
		zu   = {~zq_s2[dlf_pkg::VAL_W-1], zq_s2[dlf_pkg::VAL_W-2:0]};
		sidx = zu[dlf_pkg::VAL_W-1 -: dlf_pkg::SIG_IDX_W];
		item.neuron = n_s2;
		item.last   = last_s2;
		if (mode_s2) begin
			item.act   = dlf_pkg::VAL_W'(dlf_pkg::SIG_ACT_ROM[sidx]);
			item.slope = dlf_pkg::SIG_SLOPE_ROM[sidx];
		end else begin
			item.act   = zq_s2[dlf_pkg::VAL_W-1] ? '0 : zq_s2;
			item.slope = pos_s2 ? dlf_pkg::SLOPE_W'(4096) : '0;
		end
	end

	// result queue
	assign push = fin_s2;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign out_valid      = (count_q != '0);
	assign neuron_number  = fifo_q[rd_ptr_q].neuron;
	assign activation_out = fifo_q[rd_ptr_q].act;
	assign slope_out      = fifo_q[rd_ptr_q].slope;
	assign final_result   = fifo_q[rd_ptr_q].last;
	assign status.pop     = pop;

endmodule

// ===== hw/rtl/dense_layer_forward_unit.sv =====
// top level of the fully connected layer unit
// channel  dir  handshake               payload
// in       in   in_valid / in_ready     command, source_index, neuron_select, operand_value
// out      out  out_valid / out_ready   neuron_number, activation_out, slope_out, final_result
// cfg      in   cfg_we                  cfg_index, cfg_data
// weight and bias writes leave the unit idle and ready for the next input
// an activation passes one neuron per cycle through the shared mac, then drains
// the last activation of a run adds an evaluation pass over the n_out neurons, paced by a 4-entry result queue
// a stalled out channel stops evaluation once the queue is full; no clearing pass after reset
module dense_layer_forward_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dlf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dlf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        command,
	input  logic [dlf_pkg::ROW_W-1:0]         source_index,
	input  logic [dlf_pkg::NEUR_W-1:0]        neuron_select,
	input  logic signed [dlf_pkg::VAL_W-1:0]  operand_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dlf_pkg::NEUR_W-1:0]        neuron_number,
	output logic signed [dlf_pkg::VAL_W-1:0]  activation_out,
	output logic [dlf_pkg::SLOPE_W-1:0]       slope_out,
	output logic                              final_result
);

	dlf_pkg::ctrl_cmd_t  cmd;
	dlf_pkg::dp_status_t status;

	dlf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.command   (command),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dlf_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_accept      (in_valid && in_ready),
		.command        (command),
		.source_index   (source_index),
		.neuron_select  (neuron_select),
		.operand_value  (operand_value),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.neuron_number  (neuron_number),
		.activation_out (activation_out),
		.slope_out      (slope_out),
		.final_result   (final_result),
		.status         (status)
	);

endmodule

// ===== hw/rtl/dlf_checker.sv =====
// port checker of the dense layer unit and its bind
`include "assert_macros.svh"

module dlf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [1:0]                        command,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [dlf_pkg::NEUR_W-1:0]        neuron_number,
	input logic [dlf_pkg::SLOPE_W-1:0]       slope_out,
	input logic                              final_result
);

	`CHK_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(neuron_number))
	`CHK_NXT(a_busy_after_act, clk, arst_n, in_valid && in_ready && command == dlf_pkg::CMD_ACT, !in_ready)
	`CHK_OVL(a_neuron_order, clk, arst_n, out_valid && out_ready && !final_result ##1 out_valid, neuron_number == $past(neuron_number) + 1'b1)
	`CHK_OVL(a_slope_range, clk, arst_n, out_valid, slope_out <= dlf_pkg::SLOPE_W'(4096))

endmodule

bind dense_layer_forward_unit dlf_checker u_dlf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.command       (command),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.neuron_number (neuron_number),
	.slope_out     (slope_out),
	.final_result  (final_result)
);
